/* rtl/core/pwmle_pkg.sv */
// ----------------------------------------------------------------------------
// pwmle_pkg
// Shared types and constants of the PWM linear encoder position decoder.
// ----------------------------------------------------------------------------
package pwmle_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int FRAC_W      = FRAC_BITS + 1;
   localparam int COUNT_WIDTH = 24;
   localparam int OFFSET_W    = 48;
   localparam int POS_W       = 52;
   localparam int STAMP_W     = 32;
   localparam int SCALE_W     = 11;

   localparam logic [SCALE_W-1:0] SCALE_UM = 11'd2000;

   localparam logic [1:0] FUNC_RISE  = 2'd0;
   localparam logic [1:0] FUNC_FALL  = 2'd1;
   localparam logic [1:0] FUNC_INDEX = 2'd2;

   localparam logic [FRAC_W-1:0] FRAC_HALF = FRAC_W'(1) << (FRAC_BITS - 1);

   localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   typedef struct packed {
      logic [1:0]         func;
      logic [STAMP_W-1:0] timestamp_us;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0]       position_q16;
      logic [FRAC_W-1:0]             avg_fraction;
      logic signed [COUNT_WIDTH-1:0] edge_count;
   } rsp_type;

endpackage

/* rtl/core/pwmle_divider.sv */
// ----------------------------------------------------------------------------
// pwmle_divider
// Restoring serial divider, one quotient bit per cycle. The dividend bits
// shift out of the top of a register while the quotient shifts in below.
// ----------------------------------------------------------------------------
module pwmle_divider
   import pwmle_pkg::*;
#(
   parameter int REM_W   = 33,
   parameter int SHIFT_W = 19,
   parameter int CNT_W   = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [CNT_W-1:0]   steps,
   input  logic [REM_W-1:0]   rem_init,
   input  logic [SHIFT_W-1:0] dividend,
   input  logic [REM_W-1:0]   divisor,
   output logic               done,
   output logic [SHIFT_W-1:0] quotient
);

   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [REM_W-1:0]   divisor_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [REM_W-1:0]   trial;
   logic               fits;

   always_comb begin
      trial    = {rem_ff[REM_W-2:0], shift_ff[SHIFT_W-1]};
      fits     = (trial >= divisor_ff);
      rem_in   = fits ? (trial - divisor_ff) : trial;
      shift_in = {shift_ff[SHIFT_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         done_ff  <= 1'b0;
         count_ff <= steps;
      end else if (busy_ff) begin
         count_ff <= count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= rem_init;
         shift_ff   <= dividend;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff   <= rem_in;
         shift_ff <= shift_in;
      end
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

/* rtl/core/pwmle_position.sv */
// ----------------------------------------------------------------------------
// pwmle_position
// Two-stage position scaling: 2000 * (count + fraction) in Q16 plus offset,
// saturated to the signed output range.
// ----------------------------------------------------------------------------
module pwmle_position
   import pwmle_pkg::*;
(
   input  logic                          clock,
   input  logic signed [COUNT_WIDTH-1:0] pole_count,
   input  logic [FRAC_W-1:0]             avg_fraction,
   input  logic signed [OFFSET_W-1:0]    offset,
   output logic signed [POS_W-1:0]       position
);

   localparam int CPROD_W = COUNT_WIDTH + SCALE_W + 1;
   localparam int APROD_W = FRAC_W + SCALE_W;
   localparam int SUM_W   = POS_W + 2;

   logic signed [CPROD_W-1:0]  cprod_ff, cprod_in;
   logic [APROD_W-1:0]         aprod_ff, aprod_in;
   logic signed [OFFSET_W-1:0] offset_ff;
   logic signed [SUM_W-1:0]    total;
   logic signed [POS_W-1:0]    pos_ff, pos_in;

   always_comb begin
      cprod_in = pole_count * $signed({1'b0, SCALE_UM});
      aprod_in = avg_fraction * SCALE_UM;
      total    = SUM_W'($signed({cprod_ff, 16'b0}))
               + $signed({{(SUM_W-APROD_W){1'b0}}, aprod_ff})
               + SUM_W'(offset_ff);
      if (total[SUM_W-1:POS_W-1] == '0 || total[SUM_W-1:POS_W-1] == '1) begin
         pos_in = total[POS_W-1:0];
      end else if (total[SUM_W-1]) begin
         pos_in = POS_MIN;
      end else begin
         pos_in = POS_MAX;
      end
   end

   always_ff @(posedge clock) begin
      cprod_ff  <= cprod_in;
      aprod_ff  <= aprod_in;
      offset_ff <= offset;
      pos_ff    <= pos_in;
   end

   assign position = pos_ff;

endmodule

/* rtl/core/pwm_linear_encoder_position.sv */
// ----------------------------------------------------------------------------
// pwm_linear_encoder_position
// PWM duty-cycle position decoder with a saturating index pole counter.
// ----------------------------------------------------------------------------
// Requests are timestamped events (rise, fall, index). Each one yields one
// response with position, averaged duty fraction and pole count. One request
// is worked at a time; a request that pushes a new duty fraction runs the
// shared serial divider twice: 17 steps for the duty fraction, then one
// step per window-sum bit for the average. A new request is taken while
// the last response still waits.
// ----------------------------------------------------------------------------
module pwm_linear_encoder_position
   import pwmle_pkg::*;
#(
   parameter int WINDOW_LEN = 3,
   parameter int TIME_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_wr_en,
   input  logic [OFFSET_W-1:0]        csr_wr_data
);

   localparam int SLOT_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int SUM_W   = FRAC_W + $clog2(WINDOW_LEN);
   localparam int REM_W   = TIME_WIDTH + 1;
   localparam int CNT_W   = $clog2(SUM_W + 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_UPDATE = 4'd1;
   localparam logic [3:0] ST_CHECK  = 4'd2;
   localparam logic [3:0] ST_FDIV   = 4'd3;
   localparam logic [3:0] ST_PUSH   = 4'd4;
   localparam logic [3:0] ST_ASTART = 4'd5;
   localparam logic [3:0] ST_ADIV   = 4'd6;
   localparam logic [3:0] ST_POS1   = 4'd7;
   localparam logic [3:0] ST_POS2   = 4'd8;
   localparam logic [3:0] ST_OUT    = 4'd9;

   logic [3:0]                    state_ff, state_in;
   logic [1:0]                    func_ff;
   logic [TIME_WIDTH-1:0]         stamp_ff;
   logic [TIME_WIDTH-1:0]         last_rise_ff, period_ff, high_ff;
   logic [TIME_WIDTH-1:0]         delta;
   logic [FRAC_W-1:0]             window_ff [WINDOW_LEN];
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [SLOT_W-1:0]             slot_ff, slot_in;
   logic [FRAC_W-1:0]             avg_ff;
   logic signed [COUNT_WIDTH-1:0] count_ff;
   logic signed [OFFSET_W-1:0]    offset_ff;
   logic                          rsp_valid_ff;
   rsp_type                       rsp_data_ff;
   logic                          can_push;
   logic                          rsp_free;

   logic                          div_start;
   logic [CNT_W-1:0]              div_steps;
   logic [REM_W-1:0]              div_rem_init;
   logic [SUM_W-1:0]              div_dividend;
   logic [REM_W-1:0]              div_divisor;
   logic                          div_done;
   logic [SUM_W-1:0]              div_quotient;
   logic [FRAC_W-1:0]             frac;
   logic signed [POS_W-1:0]       position;

   pwmle_divider #(
      .REM_W   (REM_W),
      .SHIFT_W (SUM_W),
      .CNT_W   (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .steps    (div_steps),
      .rem_init (div_rem_init),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   pwmle_position u_position (
      .clock        (clock),
      .pole_count   (count_ff),
      .avg_fraction (avg_ff),
      .offset       (offset_ff),
      .position     (position)
   );

   assign delta    = stamp_ff - last_rise_ff;
   assign can_push = (period_ff != '0) && (high_ff <= period_ff);
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign frac     = div_quotient[FRAC_W-1:0];
   assign sum_in   = sum_ff - SUM_W'(window_ff[slot_ff]) + SUM_W'(frac);
   assign slot_in  = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + SLOT_W'(1);

   // fraction divide starts from high/2 so only FRAC_BITS+1 steps remain
   always_comb begin
      div_start    = 1'b0;
      div_steps    = CNT_W'(FRAC_W);
      div_rem_init = REM_W'(high_ff[TIME_WIDTH-1:1]);
      div_dividend = {high_ff[0], {(SUM_W-1){1'b0}}};
      div_divisor  = REM_W'(period_ff);
      if (state_ff == ST_CHECK) begin
         div_start = can_push;
      end else if (state_ff == ST_ASTART) begin
         div_start    = 1'b1;
         div_steps    = CNT_W'(SUM_W);
         div_rem_init = '0;
         div_dividend = sum_ff;
         div_divisor  = REM_W'(WINDOW_LEN);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_CHECK;
         ST_CHECK:  state_in = can_push ? ST_FDIV : ST_POS1;
         ST_FDIV:   if (div_done) state_in = ST_PUSH;
         ST_PUSH:   state_in = ST_ASTART;
         ST_ASTART: state_in = ST_ADIV;
         ST_ADIV:   if (div_done) state_in = ST_POS1;
         ST_POS1:   state_in = ST_POS2;
         ST_POS2:   state_in = ST_OUT;
         ST_OUT:    if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_rise_ff <= '0;
         period_ff    <= '0;
         high_ff      <= '0;
         sum_ff       <= '0;
         slot_ff      <= '0;
         avg_ff       <= '0;
         count_ff     <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            offset_ff <= csr_wr_data;
         end
         if (state_ff == ST_UPDATE) begin
            unique case (func_ff)
               FUNC_RISE: begin
                  last_rise_ff <= stamp_ff;
                  if (delta != '0) period_ff <= delta;
               end
               FUNC_FALL: begin
                  if (delta != '0) high_ff <= delta;
               end
               FUNC_INDEX: begin
                  if (avg_ff > FRAC_HALF) begin
                     if (count_ff != COUNT_MAX) count_ff <= count_ff + COUNT_WIDTH'(1);
                  end else begin
                     if (count_ff != COUNT_MIN) count_ff <= count_ff - COUNT_WIDTH'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         if (state_ff == ST_PUSH) begin
            window_ff[slot_ff] <= frac;
            sum_ff             <= sum_in;
            slot_ff            <= slot_in;
         end
         if (state_ff == ST_ADIV && div_done) begin
            avg_ff <= div_quotient[FRAC_W-1:0];
         end
         if (state_ff == ST_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         func_ff  <= req_data.func;
         stamp_ff <= req_data.timestamp_us[TIME_WIDTH-1:0];
      end
      if (state_ff == ST_OUT && rsp_free) begin
         rsp_data_ff.position_q16 <= position;
         rsp_data_ff.avg_fraction <= avg_ff;
         rsp_data_ff.edge_count   <= count_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* bench/pwm_linear_encoder_position_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwm_linear_encoder_position_tb
// Self-checking bench for the PWM duty-cycle position decoder.
// ----------------------------------------------------------------------------
// Sends rise, fall and index events over the request channel and keeps its own
// model of the period/high-time latches, the three-entry duty average, the
// saturating pole counter and the position scaling. Every response is checked
// field by field against the oldest outstanding prediction. Directed tests hit
// zero differences, wrap, full and half duty, invalid ratios and offset
// extremes; random PWM waveforms with index bursts and noise follow, under
// three backpressure profiles and several offset settings.
// ----------------------------------------------------------------------------
module pwm_linear_encoder_position_tb;
   import pwmle_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam longint UM_PER_POLE = 2000;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 60;
   localparam logic signed [OFFSET_W-1:0] OFFSET_MAX = {1'b0, {(OFFSET_W-1){1'b1}}};
   localparam logic signed [OFFSET_W-1:0] OFFSET_MIN = {1'b1, {(OFFSET_W-1){1'b0}}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [OFFSET_W-1:0] csr_wr_data = '0;

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int error_count = 0;
   int stall_cycles = 0;
   logic [STAMP_W-1:0] wave_time = '0;

   // decoder model state
   logic [STAMP_W-1:0] last_rise = '0;
   logic [STAMP_W-1:0] period_us = '0;
   logic [STAMP_W-1:0] high_us = '0;
   logic [FRAC_W-1:0] duty_win [3] = '{default: '0};
   logic [18:0] duty_sum = '0;
   int duty_slot = 0;
   logic [FRAC_W-1:0] duty_avg = '0;
   logic signed [COUNT_WIDTH-1:0] pole_cnt = '0;
   logic signed [OFFSET_W-1:0] pos_offset = '0;

   rsp_type expected_positions [$];
   rsp_type want_rsp;

   pwm_linear_encoder_position dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic rsp_type decode_event(req_type r);
      logic [STAMP_W-1:0] d;
      logic [63:0] frac;
      longint p;
      rsp_type e;
      d = r.timestamp_us - last_rise;
      case (r.func)
         FUNC_RISE: begin
            last_rise = r.timestamp_us;
            if (d != 0) period_us = d;
         end
         FUNC_FALL: begin
            if (d != 0) high_us = d;
         end
         FUNC_INDEX: begin
            if (duty_avg > FRAC_HALF) begin
               if (pole_cnt < COUNT_MAX) pole_cnt = pole_cnt + COUNT_WIDTH'(1);
            end else begin
               if (pole_cnt > COUNT_MIN) pole_cnt = pole_cnt - COUNT_WIDTH'(1);
            end
         end
         default: ;
      endcase
      if (period_us != 0 && high_us <= period_us) begin
         frac = ({32'd0, high_us} << FRAC_BITS) / {32'd0, period_us};
         duty_sum = duty_sum - duty_win[duty_slot] + frac[FRAC_W-1:0];
         duty_win[duty_slot] = frac[FRAC_W-1:0];
         duty_slot = (duty_slot + 1) % 3;
         duty_avg = FRAC_W'(duty_sum / 3);
      end
      p = longint'(pole_cnt) * UM_PER_POLE * 65536 + longint'(duty_avg) * UM_PER_POLE
          + longint'(pos_offset);
      if (p > longint'(POS_MAX)) p = longint'(POS_MAX);
      if (p < longint'(POS_MIN)) p = longint'(POS_MIN);
      e.position_q16 = p[POS_W-1:0];
      e.avg_fraction = duty_avg;
      e.edge_count = pole_cnt;
      return e;
   endfunction

   // valid is left high after acceptance; the next call either idles it or
   // replaces the payload, so each step sees a single assignment
   task automatic send_event(input logic [1:0] func, input logic [STAMP_W-1:0] stamp);
      req_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      r.func = func;
      r.timestamp_us = stamp;
      expected_positions.push_back(decode_event(r));
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_positions.size() != 0) @(posedge clock);
   endtask

   task automatic set_offset(input logic signed [OFFSET_W-1:0] value);
      drain();
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      pos_offset = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_reset_state;
      send_event(FUNC_INDEX, 32'd0);
      send_event(FUNC_UNUSED, 32'hFFFF_FFFF);
   endtask

   task automatic test_zero_difference;
      send_event(FUNC_RISE, 32'd0);
      send_event(FUNC_FALL, 32'd0);
      send_event(FUNC_RISE, 32'd1000);
      send_event(FUNC_FALL, 32'd1000);
      send_event(FUNC_FALL, 32'd1750);
      send_event(FUNC_RISE, 32'd1000);
   endtask

   // high time equal to the period across the timestamp wrap
   task automatic test_full_duty;
      send_event(FUNC_RISE, 32'hFFFF_FFF0);
      send_event(FUNC_RISE, 32'h0000_0010);
      send_event(FUNC_FALL, 32'h0000_0030);
      send_event(FUNC_UNUSED, 32'h0000_0000);
      send_event(FUNC_UNUSED, 32'hFFFF_FFFF);
      send_event(FUNC_INDEX, 32'h0000_0040);
   endtask

   // average exactly one half must count down
   task automatic test_half_duty;
      send_event(FUNC_RISE, 32'h0000_0100);
      send_event(FUNC_RISE, 32'h0000_0102);
      send_event(FUNC_FALL, 32'h0000_0103);
      send_event(FUNC_UNUSED, 32'h5555_5555);
      send_event(FUNC_UNUSED, 32'hAAAA_AAAA);
      send_event(FUNC_INDEX, 32'h0000_0104);
   endtask

   task automatic test_invalid_ratio;
      send_event(FUNC_RISE, 32'h0000_0200);
      send_event(FUNC_RISE, 32'h0000_0264);
      send_event(FUNC_FALL, 32'h0000_0300);
      send_event(FUNC_RISE, 32'h0000_0263);
      send_event(FUNC_FALL, 32'h0000_0261);
   endtask

   task automatic test_offset_extremes;
      set_offset(OFFSET_MAX);
      send_event(FUNC_INDEX, 32'hFFFF_FFFF);
      set_offset(OFFSET_MIN);
      send_event(FUNC_UNUSED, 32'h0000_0000);
      set_offset('0);
   endtask

   // mostly clean PWM periods with random duty, plus index bursts and noise
   task automatic test_random_events(input int count);
      int sent;
      int pick;
      int burst;
      logic [STAMP_W-1:0] period;
      logic [STAMP_W-1:0] high;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            period = ($urandom_range(9) == 0) ? $urandom : $urandom_range(5000, 1);
            case ($urandom_range(9))
               0: high = '0;
               1: high = period;
               2: high = period + $urandom_range(50, 1);
               default: high = $urandom_range(period, 0);
            endcase
            send_event(FUNC_RISE, wave_time);
            send_event(FUNC_FALL, wave_time + high);
            sent += 2;
            if ($urandom_range(3) == 0) begin
               send_event(FUNC_INDEX, wave_time + $urandom_range(period, 0));
               sent++;
            end
            wave_time = wave_time + period;
         end else if (pick < 85) begin
            burst = $urandom_range(4, 1);
            repeat (burst) send_event(FUNC_INDEX, $urandom);
            sent += burst;
         end else begin
            send_event(2'($urandom_range(3)),
                       ($urandom_range(1) == 0) ? $urandom : wave_time);
            sent++;
         end
      end
   endtask

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_positions.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want_rsp = expected_positions.pop_front();
            if (rsp_data.position_q16 !== want_rsp.position_q16) begin
               $error("position_q16: expected %0d, actual %0d",
                      want_rsp.position_q16, rsp_data.position_q16);
               error_count++;
            end
            if (rsp_data.avg_fraction !== want_rsp.avg_fraction) begin
               $error("avg_fraction: expected %0d, actual %0d",
                      want_rsp.avg_fraction, rsp_data.avg_fraction);
               error_count++;
            end
            if (rsp_data.edge_count !== want_rsp.edge_count) begin
               $error("edge_count: expected %0d, actual %0d",
                      want_rsp.edge_count, rsp_data.edge_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("pwm_linear_encoder_position regression: fail");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 14;
      rsp_idle_pct = 77;
      test_reset_state();
      test_zero_difference();
      test_full_duty();
      test_half_duty();
      test_invalid_ratio();
      test_offset_extremes();
      wave_time = $urandom;
      set_offset(OFFSET_MAX);
      test_random_events(360);
      send_idle_pct = 77;
      rsp_idle_pct = 14;
      set_offset(OFFSET_MIN);
      test_random_events(360);
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      set_offset(OFFSET_W'({$urandom, $urandom}));
      test_random_events(360);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("pwm_linear_encoder_position regression: pass");
      end else begin
         $display("pwm_linear_encoder_position regression: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/pwmle_pkg.sv
rtl/core/pwmle_divider.sv
rtl/core/pwmle_position.sv
rtl/core/pwm_linear_encoder_position.sv
bench/pwm_linear_encoder_position_tb.sv
